// File: sv/tsm_pkg.sv
// Shared types, codes and constants of the timestamp stream merger.
`default_nettype none

package tsm_pkg;

    // Upper bound on the results that one request may cause.
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_KEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd2;
    localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 3'd4;

    // Input operation codes.
    localparam logic OP_TIME = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int TIME_W = 64;

    typedef enum logic [1:0] {
        KIND_MERGED   = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_IGNORED  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_DECIDE,
        ST_EMIT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_scan;
        logic rd;
        logic cmp;
        logic pop;
        logic emit;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any;
        logic blocked;
        logic last_idx;
        logic hb_drop;
        logic pend_valid;
        logic out_free;
        logic limit;
    } t_status;

endpackage

`default_nettype wire

// File: sv/timestamp_stream_merger_core.sv
// Top level of the timestamp stream merger: controller plus datapath.
//
// Usage: requests enter on the slave stream. tuser carries the operation
// (timestamp or end of stream) and the source channel; tdata carries the
// signed 64-bit tick count. Results leave on the master stream, ordered by
// timestamp magnitude with ties going to the lowest channel; tuser carries
// the result kind and the route, and tlast marks the final result that one
// request causes. A request that causes no result produces no beat at all.
// Configuration is written through a plain write port while no request is
// in flight; the registers take effect on the next request.
//
// Timing: one request is handled at a time. Each merge step scans the
// heads of the A active channels through the single FIFO memory read port,
// with a read step and a compare step per channel, then decides and pops,
// and then emits; a popped negative timestamp that is not kept is dropped
// and a new scan starts. A request ends, after a finish step, once a scan
// finds nothing eligible or is blocked by an empty channel that has not
// ended, or once the result limit is reached. Each result is held in the
// pending slot until the next one proves it is not the last.
// Reset clears all FIFO pointers, fill counts and end marks at once.
// A stalled receiver holds the result in the output register; the block
// then waits before handing over its next result and loses nothing.
`default_nettype none

module timestamp_stream_merger_core
    import tsm_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [63:0]           i_s_axis_tdata,  // time_in[63:0]
    input  wire logic [2:0]            i_s_axis_tuser,  // op[0], channel[2:1]
    // Result stream.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [63:0]                o_m_axis_tdata,  // time_out[63:0]
    output logic [3:0]                 o_m_axis_tuser,  // kind[1:0], route[3:2]
    output logic                       o_m_axis_tlast
);

    t_cmd       cmd;
    t_status    status;
    logic [1:0] kind;
    logic [1:0] route;

    // The controller sequences accept, scan, pop and emit steps; it never
    // touches payload and sees the datapath only through the status bundle.
    tsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    tsm_datapath #(
        .CHANNELS   (CHANNELS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_axis_tuser[0]),
        .i_ch        (i_s_axis_tuser[2:1]),
        .i_time      (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_kind      (kind),
        .o_time      (o_m_axis_tdata),
        .o_route     (route),
        .o_last      (o_m_axis_tlast)
    );

    // Kind sits in the low bits of tuser, the route above it.
    assign o_m_axis_tuser = {route, kind};

endmodule

`default_nettype wire

// File: sv/tsm_ctrl.sv
// Sequencing state machine of the timestamp stream merger.
`default_nettype none

module tsm_ctrl
    import tsm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   can_move;

    // A new result may enter the pending slot only when the old one can leave.
    assign can_move = !i_status.pend_valid || i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                n_state = i_status.last_idx ? ST_DECIDE : ST_READ;
            end
            ST_DECIDE: begin
                if (!i_status.any || i_status.blocked) begin
                    n_state = ST_FINISH;
                end else if (i_status.hb_drop) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_move) n_state = i_status.limit ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (can_move) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.accept   = i_in_valid;
                o_cmd.clr_scan = i_in_valid;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            ST_COMPARE: begin
                o_cmd.cmp = 1'b1;
            end
            ST_DECIDE: begin
                if (i_status.any && !i_status.blocked) begin
                    o_cmd.pop      = 1'b1;
                    o_cmd.clr_scan = i_status.hb_drop;
                end
            end
            ST_EMIT: begin
                o_cmd.emit     = can_move;
                o_cmd.clr_scan = can_move;
            end
            ST_FINISH: begin
                o_cmd.finish = can_move;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tsm_datapath.sv
// Channel FIFOs, head scan, pending result and output register of the merger.
`default_nettype none

module tsm_datapath
    import tsm_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_op,
    input  wire logic [1:0]            i_ch,
    input  wire logic [TIME_W-1:0]     i_time,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_m_ready,
    output logic                       o_m_valid,
    output logic [1:0]                 o_kind,
    output logic [TIME_W-1:0]          o_time,
    output logic [1:0]                 o_route,
    output logic                       o_last
);

    localparam int CHW   = $clog2(CHANNELS);
    localparam int CXW   = (CHW > 2) ? CHW : 2;
    localparam int AW    = $clog2(CHANNELS + 1);
    localparam int LW    = (AW > 3) ? AW : 3;
    localparam int PW    = $clog2(FIFO_DEPTH);
    localparam int FW    = $clog2(FIFO_DEPTH + 1);
    localparam int DEPTH = CHANNELS * FIFO_DEPTH;
    localparam int MW    = $clog2(DEPTH);

    // Configuration registers.
    logic                  r_hb_keep;
    logic                  r_routed;
    logic [CFG_DATA_W-1:0] r_active;

    // Per-channel FIFO control.
    logic [PW-1:0]       r_rp   [CHANNELS];
    logic [PW-1:0]       r_wp   [CHANNELS];
    logic [FW-1:0]       r_fill [CHANNELS];
    logic [CHANNELS-1:0] r_ended;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    // Head scan.
    logic [CHW-1:0]    r_idx;
    logic              r_any;
    logic              r_blocked;
    logic [CHW-1:0]    r_best;
    logic [TIME_W-1:0] r_best_mag;
    logic [TIME_W-1:0] r_best_val;

    // Pending result, held back until it is known whether it is the last one.
    logic              r_pend_valid;
    t_kind             r_pend_kind;
    logic [TIME_W-1:0] r_pend_time;
    logic [1:0]        r_pend_route;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [TIME_W-1:0] r_out_time;
    logic [1:0]        r_out_route;
    logic              r_out_last;

    logic [LW-1:0]     act_l;
    logic [CXW-1:0]    ch_x;
    logic [CHW-1:0]    ch_idx;
    logic [CXW-1:0]    best_x;
    logic [CHW-1:0]    sel;
    logic [FW-1:0]     sel_fill;
    logic              sel_ended;
    logic [PW-1:0]     sel_rp;
    logic [PW-1:0]     sel_wp;
    logic [PW-1:0]     rp_inc;
    logic [PW-1:0]     wp_inc;
    logic [MW-1:0]     addr;
    logic              in_range;
    logic              ign;
    logic              ovf;
    logic              wr;
    logic              endm;
    logic              all_done;
    logic              out_free;
    logic              load_out;
    logic [TIME_W-1:0] mag;

    // Active channel count, clamped to one..CHANNELS.
    always_comb begin
        act_l = LW'(r_active);
        if (act_l == '0) begin
            act_l = LW'(1);
        end else if (act_l > LW'(CHANNELS)) begin
            act_l = LW'(CHANNELS);
        end
    end

    assign ch_x   = CXW'(i_ch);
    assign ch_idx = ch_x[CHW-1:0];
    assign best_x = CXW'(r_best);

    // The per-channel arrays are looked up at one shared index; only the end check reads every channel.
    always_comb begin
        if (i_cmd.accept) begin
            sel = ch_idx;
        end else if (i_cmd.pop) begin
            sel = r_best;
        end else begin
            sel = r_idx;
        end
    end

    assign sel_fill  = r_fill[sel];
    assign sel_ended = r_ended[sel];
    assign sel_rp    = r_rp[sel];
    assign sel_wp    = r_wp[sel];
    assign rp_inc    = (sel_rp == PW'(FIFO_DEPTH - 1)) ? '0 : sel_rp + PW'(1);
    assign wp_inc    = (sel_wp == PW'(FIFO_DEPTH - 1)) ? '0 : sel_wp + PW'(1);
    assign addr      = MW'(sel) * MW'(FIFO_DEPTH) + MW'(i_cmd.accept ? sel_wp : sel_rp);

    assign in_range = LW'(i_ch) < act_l;
    assign ign      = !in_range || sel_ended;
    assign ovf      = !ign && (i_op == OP_TIME) && (sel_fill == FW'(FIFO_DEPTH));
    assign wr       = !ign && (i_op == OP_TIME) && !ovf;
    assign endm     = !ign && (i_op == OP_END);

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (LW'(i) < act_l && (!r_ended[i] || r_fill[i] != '0)) all_done = 1'b0;
        end
    end

    // Magnitude; the most negative value maps to two to the 63rd.
    assign mag = r_rdata[TIME_W-1] ? (TIME_W'(0) - r_rdata) : r_rdata;

    assign out_free = !r_out_valid || i_m_ready;
    assign load_out = r_pend_valid && (i_cmd.emit || i_cmd.finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_keep <= 1'b0;
            r_routed  <= 1'b0;
            r_active  <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HB_KEEP: r_hb_keep <= i_cfg_wdata[0];
                CFG_ROUTED:  r_routed  <= i_cfg_wdata[0];
                CFG_ACTIVE:  r_active  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rp[i]   <= '0;
                r_wp[i]   <= '0;
                r_fill[i] <= '0;
            end
            r_ended <= '0;
        end else begin
            if (i_cmd.accept && wr) begin
                r_wp[sel]   <= wp_inc;
                r_fill[sel] <= sel_fill + FW'(1);
            end
            if (i_cmd.accept && endm) begin
                r_ended[sel] <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_rp[sel]   <= rp_inc;
                r_fill[sel] <= sel_fill - FW'(1);
            end
            if (i_cmd.finish && all_done) begin
                r_ended <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr) begin
            r_mem[addr] <= i_time;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_any     <= 1'b0;
            r_blocked <= 1'b0;
        end else if (i_cmd.clr_scan) begin
            r_idx     <= '0;
            r_any     <= 1'b0;
            r_blocked <= 1'b0;
        end else if (i_cmd.cmp) begin
            r_idx <= r_idx + CHW'(1);
            if (sel_fill == '0) begin
                if (!sel_ended) r_blocked <= 1'b1;
            end else if (!r_any || mag < r_best_mag) begin
                r_any <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && sel_fill != '0 && (!r_any || mag < r_best_mag)) begin
            r_best     <= r_idx;
            r_best_mag <= mag;
            r_best_val <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else if (i_cmd.accept) begin
            r_pend_valid <= ign || ovf;
            r_cnt        <= (ign || ovf) ? CNT_W'(1) : '0;
        end else if (i_cmd.emit) begin
            r_pend_valid <= 1'b1;
            r_cnt        <= r_cnt + CNT_W'(1);
        end else if (i_cmd.finish) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_kind  <= ign ? KIND_IGNORED : KIND_OVERFLOW;
            r_pend_time  <= (ign && i_op == OP_END) ? '0 : i_time;
            r_pend_route <= r_routed ? i_ch : 2'd0;
        end else if (i_cmd.emit) begin
            r_pend_kind  <= KIND_MERGED;
            r_pend_time  <= r_best_val;
            r_pend_route <= r_routed ? best_x[1:0] : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind  <= r_pend_kind;
            r_out_time  <= r_pend_time;
            r_out_route <= r_pend_route;
            r_out_last  <= i_cmd.finish;
        end
    end

    assign o_status.any        = r_any;
    assign o_status.blocked    = r_blocked;
    assign o_status.last_idx   = (LW'(r_idx) + LW'(1)) == act_l;
    assign o_status.hb_drop    = r_best_val[TIME_W-1] && !r_hb_keep;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;
    assign o_status.limit      = r_cnt == CNT_W'(MAX_RESULTS - 1);

    assign o_m_valid = r_out_valid;
    assign o_kind    = r_out_kind;
    assign o_time    = r_out_time;
    assign o_route   = r_out_route;
    assign o_last    = r_out_last;

`ifndef NO_ASSERTIONS
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !r_pend_valid && r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("request accepted while a result was still pending");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("output register overwritten before it was taken");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_any && !r_blocked && sel_fill != '0)
        else $error("pop from an empty or blocked scan");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond its limit");
`endif

endmodule

`default_nettype wire
